// ===== hw/rtl/htfl_pkg.sv =====
// Shared types and constants for the handle table with LIFO free list.
// No dependencies; imported by htfl_store and handle_table_free_list.
`default_nettype none
package htfl_pkg;

    localparam int HANDLES_PER_BLOCK = 64;
    localparam int TOTAL_HANDLES     = 1024;
    localparam int POOL_CAPACITY     = (TOTAL_HANDLES / HANDLES_PER_BLOCK) * HANDLES_PER_BLOCK;

    localparam int HANDLE_W = $clog2(TOTAL_HANDLES);
    localparam int COUNT_W  = $clog2(TOTAL_HANDLES + 1);
    localparam int OBJ_W    = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] STACK_EMPTY = COUNT_W'(TOTAL_HANDLES);
    localparam logic [COUNT_W-1:0] CAPACITY    = COUNT_W'(POOL_CAPACITY);

    // input tdata: req_type, handle_index, object_value; padded to bytes
    localparam int S_DATA_BITS = REQ_W + HANDLE_W + OBJ_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    // output tdata: status, handle_out, object_out, live_count; padded to bytes
    localparam int M_DATA_BITS = STATUS_W + HANDLE_W + OBJ_W + COUNT_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE  = 2'd0,
        REQ_DESTROY = 2'd1,
        REQ_LOOKUP  = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2,
        ST_RSVD    = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fsm_t;

    // one table entry: in-use flag and object value (or free link)
    typedef struct packed {
        logic             in_use;
        logic [OBJ_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic                rd_en;
        logic [HANDLE_W-1:0] rd_addr;
        logic                wr_en;
        logic [HANDLE_W-1:0] wr_addr;
        entry_t              wr_data;
    } store_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/handle_table_free_list.sv =====
// Handle table top level: request/result streams, control and head registers.
// Depends on htfl_pkg and htfl_store.
//
// Usage:
//   s_t* carries one request per transaction (create, destroy, lookup).
//   m_t* carries exactly one result per request, in request order.
//   A request is taken when the block is idle; the entry is read from the
//   store in that cycle and the result is written to the output register
//   from the execute state once that register is free; a create or destroy
//   writes the entry back in that state. A new request is taken only after
//   the result of the current one has been written.
//   m_tvalid rises when that result is written to the output register.
//   The output register frees the input side: a new request is taken while
//   a result waits. If the receiver stalls with a result still held, the
//   next request waits in the execute state until the register frees up.
//   Reset (aresetn low, synchronous) empties the free stack and marks all
//   handles as never used; the store itself needs no clearing because
//   entries at or above the fresh-handle counter are never trusted.
`default_nettype none
module handle_table_free_list (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [1:0] req_type, [11:2] handle_index, [43:12] object_value
    input  wire logic [htfl_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [1:0] status, [11:2] handle_out, [43:12] object_out, [54:44] live_count
    output logic [htfl_pkg::M_DATA_W-1:0]        m_tdata
);
    import htfl_pkg::*;

    localparam int H_LO = REQ_W;
    localparam int O_LO = REQ_W + HANDLE_W;

    fsm_t                state_reg, state_next;
    req_t                req_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [OBJ_W-1:0]    obj_reg;
    logic [COUNT_W-1:0]  head_reg, head_next;
    logic [COUNT_W-1:0]  fresh_reg, fresh_next;
    logic [COUNT_W-1:0]  live_reg, live_next;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    store_ctl_t          ctl;
    entry_t              rd_data;

    logic                s_accept;
    logic                done;
    req_t                s_req;
    logic                holds;
    status_t             status;
    logic [HANDLE_W-1:0] hout;
    logic [OBJ_W-1:0]    oout;

    htfl_store u_store (
        .aclk    (aclk),
        .ctl     (ctl),
        .rd_data (rd_data)
    );

    assign s_req    = req_t'(s_tdata[REQ_W-1:0]);
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign done     = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    // handle is live and has a non-null object; entries at or above the
    // fresh counter were never written and count as free
    assign holds = ({1'b0, handle_reg} < fresh_reg) && rd_data.in_use
                   && (rd_data.value != '0);

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        fresh_next = fresh_reg;
        live_next  = live_reg;
        status     = ST_INVALID;
        hout       = handle_reg;
        oout       = '0;

        ctl.rd_en   = s_accept;
        ctl.rd_addr = (s_req == REQ_CREATE) ? head_reg[HANDLE_W-1:0]
                                            : s_tdata[H_LO +: HANDLE_W];
        ctl.wr_en   = 1'b0;
        ctl.wr_addr = handle_reg;
        ctl.wr_data = '{in_use: 1'b0, value: OBJ_W'(head_reg)};

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (req_reg)
                    REQ_CREATE: begin
                        hout = '0;
                        if (head_reg < STACK_EMPTY) begin
                            // pop: stored word of a free entry is the next link
                            hout      = head_reg[HANDLE_W-1:0];
                            head_next = (rd_data.value > OBJ_W'(TOTAL_HANDLES))
                                        ? STACK_EMPTY : rd_data.value[COUNT_W-1:0];
                            status    = ST_OK;
                        end else if (fresh_reg < CAPACITY) begin
                            hout       = fresh_reg[HANDLE_W-1:0];
                            fresh_next = fresh_reg + 1'b1;
                            status     = ST_OK;
                        end else begin
                            status = ST_FULL;
                        end
                        if (status == ST_OK) begin
                            ctl.wr_addr = hout;
                            ctl.wr_data = '{in_use: 1'b1, value: obj_reg};
                            live_next   = live_reg + 1'b1;
                        end
                    end
                    REQ_DESTROY: begin
                        if (holds) begin
                            oout      = rd_data.value;
                            head_next = {1'b0, handle_reg};
                            if (live_reg != '0) begin
                                live_next = live_reg - 1'b1;
                            end
                            status = ST_OK;
                        end
                    end
                    REQ_LOOKUP: begin
                        if (holds) begin
                            oout   = rd_data.value;
                            status = ST_OK;
                        end
                    end
                    default: begin
                        status = ST_INVALID;
                    end
                endcase
                ctl.wr_en = done && (status == ST_OK) && (req_reg != REQ_LOOKUP);
                if (!done) begin
                    head_next  = head_reg;
                    fresh_next = fresh_reg;
                    live_next  = live_reg;
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= STACK_EMPTY;
            fresh_reg   <= '0;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fresh_reg <= fresh_next;
            live_reg  <= live_next;
            if (done) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg    <= s_req;
            handle_reg <= s_tdata[H_LO +: HANDLE_W];
            obj_reg    <= s_tdata[O_LO +: OBJ_W];
        end
        if (done) begin
            m_data_reg <= M_DATA_W'({live_next, oout, hout, status});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/htfl_store.sv =====
// Entry store: one-write, one-read synchronous RAM holding table entries.
// Depends on htfl_pkg for entry and control types.
`default_nettype none
module htfl_store (
    input  wire logic                aclk,
    input  wire htfl_pkg::store_ctl_t ctl,
    output htfl_pkg::entry_t         rd_data
);
    import htfl_pkg::*;

    entry_t mem [TOTAL_HANDLES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
    end

    // read data holds between reads
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== dv/handle_table_free_list_test.sv =====
// Self-checking testbench for handle_table_free_list: request stream in, result stream out.
// Depends on htfl_pkg and the RTL only; each result is checked against a typed plan row or a built-in table model.
`timescale 1ns / 1ps
module handle_table_free_list_test;
    import htfl_pkg::*;

    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int LONG_HOLD    = 300;

    // packed so that status lands in the low bits, matching m_tdata
    typedef struct packed {
        logic [COUNT_W-1:0]  live;
        logic [OBJ_W-1:0]    obj;
        logic [HANDLE_W-1:0] handle;
        status_t             status;
    } result_t;

    // reps > 1: repeat with random handle and object, predictor checked
    typedef struct packed {
        req_t                rq;
        logic [HANDLE_W-1:0] h;
        logic [OBJ_W-1:0]    obj;
        logic [15:0]         reps;
        logic                typed;
        result_t             want;
    } plan_row_t;

    localparam int PLAN_ROWS = 24;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // table model state
    logic [OBJ_W-1:0] tbl_val  [TOTAL_HANDLES];
    bit               tbl_used [TOTAL_HANDLES];
    int               free_top;
    int               fresh_next;
    int               live_now;

    result_t pending_results [$];
    int      errors     = 0;
    int      rx_count   = 0;
    int      cycle_cnt  = 0;
    int      hold_cnt   = 0;
    bit      held_long  = 1'b0;
    bit      rx_steady  = 1'b0;
    bit      tx_steady  = 1'b0;
    int      items_sent = 0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{REQ_LOOKUP,  10'd0,    32'h0,        16'd1, 1'b1, '{11'd0, 32'h0, 10'd0, ST_INVALID}},
        '{REQ_DESTROY, 10'd1023, 32'hFFFFFFFF, 16'd1, 1'b1, '{11'd0, 32'h0, 10'd1023, ST_INVALID}},
        '{REQ_NONE,    10'h2AA,  32'hFFFFFFFF, 16'd1, 1'b1, '{11'd0, 32'h0, 10'h2AA, ST_INVALID}},
        '{REQ_CREATE,  10'd1023, 32'hFFFFFFFF, 16'd1, 1'b1, '{11'd1, 32'h0, 10'd0, ST_OK}},
        // null object: in use but never found
        '{REQ_CREATE,  10'd0,    32'h0,        16'd1, 1'b1, '{11'd2, 32'h0, 10'd1, ST_OK}},
        '{REQ_LOOKUP,  10'd1,    32'h0,        16'd1, 1'b1, '{11'd2, 32'h0, 10'd1, ST_INVALID}},
        '{REQ_DESTROY, 10'd1,    32'h0,        16'd1, 1'b1, '{11'd2, 32'h0, 10'd1, ST_INVALID}},
        '{REQ_LOOKUP,  10'd0,    32'h0,        16'd1, 1'b1, '{11'd2, 32'hFFFFFFFF, 10'd0, ST_OK}},
        '{REQ_CREATE,  10'd0,    32'h1,        16'd1, 1'b1, '{11'd3, 32'h0, 10'd2, ST_OK}},
        '{REQ_DESTROY, 10'd0,    32'h0,        16'd1, 1'b1, '{11'd2, 32'hFFFFFFFF, 10'd0, ST_OK}},
        '{REQ_LOOKUP,  10'd0,    32'h0,        16'd1, 1'b1, '{11'd2, 32'h0, 10'd0, ST_INVALID}},
        '{REQ_DESTROY, 10'd2,    32'h0,        16'd1, 1'b1, '{11'd1, 32'h1, 10'd2, ST_OK}},
        // free stack is LIFO: 2 comes back before 0
        '{REQ_CREATE,  10'd0,    32'h5A5A5A5A, 16'd1, 1'b1, '{11'd2, 32'h0, 10'd2, ST_OK}},
        '{REQ_CREATE,  10'd0,    32'hA5A5A5A5, 16'd1, 1'b1, '{11'd3, 32'h0, 10'd0, ST_OK}},
        '{REQ_CREATE,  10'd0,    32'h80000000, 16'd1, 1'b1, '{11'd4, 32'h0, 10'd3, ST_OK}},
        // fill up to capacity
        '{REQ_CREATE,  10'd0,    32'h0,        16'd1020, 1'b0, '0},
        '{REQ_CREATE,  10'd5,    32'h12345678, 16'd1, 1'b1, '{11'd1024, 32'h0, 10'd0, ST_FULL}},
        '{REQ_LOOKUP,  10'd1023, 32'h0,        16'd1, 1'b0, '0},
        '{REQ_DESTROY, 10'd1023, 32'h0,        16'd1, 1'b0, '0},
        '{REQ_DESTROY, 10'd512,  32'h0,        16'd1, 1'b0, '0},
        '{REQ_CREATE,  10'd0,    32'h7,        16'd1, 1'b1, '{11'd1023, 32'h0, 10'd512, ST_OK}},
        '{REQ_CREATE,  10'd0,    32'h8,        16'd1, 1'b1, '{11'd1024, 32'h0, 10'd1023, ST_OK}},
        '{REQ_CREATE,  10'd0,    32'h9,        16'd1, 1'b1, '{11'd1024, 32'h0, 10'd0, ST_FULL}},
        '{REQ_NONE,    10'd0,    32'h0,        16'd1, 1'b1, '{11'd1024, 32'h0, 10'd0, ST_INVALID}}
    };

    handle_table_free_list dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic result_t apply_request(req_t rq, logic [HANDLE_W-1:0] h,
                                              logic [OBJ_W-1:0] obj);
        result_t res;
        int      slot;
        bit      owned;
        res.status = ST_INVALID;
        res.handle = h;
        res.obj    = '0;
        owned = tbl_used[h] && tbl_val[h] != '0;
        case (rq)
            REQ_CREATE: begin
                res.handle = '0;
                slot = -1;
                if (free_top < TOTAL_HANDLES) begin
                    slot = free_top;
                    // a link past the end counts as the end marker
                    free_top = (tbl_val[slot] > TOTAL_HANDLES) ? TOTAL_HANDLES
                                                                : int'(tbl_val[slot]);
                end else if (fresh_next < POOL_CAPACITY) begin
                    slot = fresh_next;
                    fresh_next++;
                end
                if (slot >= 0) begin
                    tbl_val[slot]  = obj;
                    tbl_used[slot] = 1'b1;
                    live_now++;
                    res.status = ST_OK;
                    res.handle = HANDLE_W'(slot);
                end else begin
                    res.status = ST_FULL;
                end
            end
            REQ_DESTROY: begin
                if (owned) begin
                    res.obj     = tbl_val[h];
                    tbl_val[h]  = OBJ_W'(free_top);
                    tbl_used[h] = 1'b0;
                    free_top    = int'(h);
                    if (live_now > 0) live_now--;
                    res.status = ST_OK;
                end
            end
            REQ_LOOKUP: begin
                if (owned) begin
                    res.obj    = tbl_val[h];
                    res.status = ST_OK;
                end
            end
            default: ;
        endcase
        res.live = COUNT_W'(live_now);
        return res;
    endfunction

    // some handle that currently holds an object, if any exists
    function automatic logic [HANDLE_W-1:0] pick_live();
        int start;
        int idx;
        start = $urandom_range(0, TOTAL_HANDLES - 1);
        for (int k = 0; k < TOTAL_HANDLES; k++) begin
            idx = (start + k) % TOTAL_HANDLES;
            if (tbl_used[idx] && tbl_val[idx] != '0) return HANDLE_W'(idx);
        end
        return HANDLE_W'(start);
    endfunction

    task automatic send_request(input req_t rq, input logic [HANDLE_W-1:0] h,
                                input logic [OBJ_W-1:0] obj, input bit typed,
                                input result_t typed_want);
        int      gap;
        result_t predicted;
        gap = idle_len(tx_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({obj, h, rq});
        do @(posedge aclk); while (!s_tready);
        predicted = apply_request(rq, h, obj);
        pending_results.push_back(typed ? typed_want : predicted);
        items_sent++;
        if (items_sent % 40 == 0) tx_steady = ($urandom_range(0, 2) == 0);
    endtask

    function automatic void report(string what, result_t want, result_t got);
        errors++;
        if (errors <= 10)
            $display("%s: want st=%0d h=%0d obj=%h live=%0d, got st=%0d h=%0d obj=%h live=%0d",
                     what, want.status, want.handle, want.obj, want.live,
                     got.status, got.handle, got.obj, got.live);
    endfunction

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    // receiver: random stalls, one long hold-off once traffic is going
    always @(posedge aclk) begin : rx_side
        int n;
        if (cycle_cnt % 128 == 0) rx_steady <= ($urandom_range(0, 2) == 0);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (rx_count >= 200 && !held_long) begin
            m_tready  <= 1'b0;
            hold_cnt  <= LONG_HOLD - 1;
            held_long <= 1'b1;
        end else begin
            n = (rx_steady || $urandom_range(0, 3) != 0) ? 0 : idle_len(1'b0);
            if (n > 0) begin
                m_tready <= 1'b0;
                hold_cnt <= n - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[M_DATA_BITS-1:0]);
            rx_count <= rx_count + 1;
            if (pending_results.size() == 0) begin
                report("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.handle !== want.handle ||
                    got.obj !== want.obj || got.live !== want.live)
                    report("mismatch", want, got);
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        req_t                rq;
        logic [HANDLE_W-1:0] h;
        logic [OBJ_W-1:0]    obj;
        int                  r;
        int                  create_share;
        for (int i = 0; i < TOTAL_HANDLES; i++) begin
            tbl_val[i]  = '0;
            tbl_used[i] = 1'b0;
        end
        free_top   = TOTAL_HANDLES;
        fresh_next = 0;
        live_now   = 0;

        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_ROWS; i++) begin
            for (int k = 0; k < plan[i].reps; k++) begin
                if (plan[i].reps > 1)
                    send_request(plan[i].rq, HANDLE_W'($urandom_range(0, TOTAL_HANDLES - 1)),
                                 $urandom, 1'b0, plan[i].want);
                else
                    send_request(plan[i].rq, plan[i].h, plan[i].obj, plan[i].typed,
                                 plan[i].want);
            end
        end

        // first half drains the table, second half fills it back up
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            create_share = (n < RANDOM_ITEMS / 2) ? 20 : 50;
            h   = HANDLE_W'($urandom_range(0, TOTAL_HANDLES - 1));
            obj = $urandom;
            if (r < create_share) begin
                rq = REQ_CREATE;
            end else if (r < 90) begin
                rq = ($urandom_range(0, 4) < 3) ? REQ_DESTROY : REQ_LOOKUP;
                h  = pick_live();
            end else if (r < 97) begin
                rq = $urandom_range(0, 1) ? REQ_DESTROY : REQ_LOOKUP;
            end else begin
                rq = REQ_NONE;
            end
            send_request(rq, h, obj, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
